>>> hdl/dup_pkg.sv
package dup_pkg;

    // Characters recognized by the parser
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Configuration register indexes
    localparam logic CFG_DOT_MODE = 1'b0;
    localparam logic CFG_STRIP_CR = 1'b1;

    // Result queue sizing: room for a two-result push on top of two queued entries
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // Line phase; encodings 5..7 are never produced and decode as start of line
    typedef enum logic [2:0] {
        PH_SOL   = 3'd0,  // start of line
        PH_MID   = 3'd1,  // inside a line
        PH_DOT   = 3'd2,  // leading dot held back
        PH_DOTCR = 3'd3,  // leading dot and CR held back
        PH_EOD   = 3'd4   // terminator seen, bytes ignored
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_line;
        logic       end_of_data;
        logic       last;
    } res_t;

    // Outcome of handling one byte as part of a line body
    typedef struct packed {
        logic   emit;
        res_t   res;
        phase_t ph;
    } mid_t;

    // Decision for one input byte, core -> top
    typedef struct packed {
        logic [1:0]      cnt;
        res_t [1:0]      res;
        phase_t          ph_next;
    } step_t;

    function automatic mid_t mid_line(input logic [7:0] b, input logic strip);
        mid_t m;
        m.emit            = 1'b1;
        m.res.out_byte    = b;
        m.res.end_of_line = 1'b0;
        m.res.end_of_data = 1'b0;
        m.res.last        = 1'b0;
        if (b == CH_LF) begin
            m.res.end_of_line = 1'b1;
            m.ph              = PH_SOL;
        end else begin
            m.emit = (b != CH_CR) || !strip;
            m.ph   = PH_MID;
        end
        return m;
    endfunction

endpackage

>>> hdl/dup_core.sv
module dup_core
    import dup_pkg::*;
(
    input  logic [7:0] in_byte,
    input  logic       restart,
    input  phase_t     phase,
    input  logic       dot_mode,
    input  logic       strip_cr,
    output step_t      step
);

    phase_t ph;
    mid_t   m;
    logic   use_mid;
    logic   extra_cr;
    logic   eod;

    always_comb begin
        ph       = restart ? PH_SOL : phase;
        m        = mid_line(in_byte, strip_cr);
        use_mid  = 1'b0;
        extra_cr = 1'b0;
        eod      = 1'b0;
        step.ph_next = ph;

        priority if (ph == PH_EOD) begin
            step.ph_next = PH_EOD;
        end else if (!dot_mode) begin
            use_mid = 1'b1;
        end else begin
            unique case (ph)
                PH_MID: begin
                    use_mid = 1'b1;
                end
                PH_DOT: begin
                    if (in_byte == CH_CR) begin
                        step.ph_next = PH_DOTCR;
                    end else begin
                        use_mid = 1'b1;
                    end
                end
                PH_DOTCR: begin
                    if (in_byte == CH_LF) begin
                        eod          = 1'b1;
                        step.ph_next = PH_EOD;
                    end else begin
                        extra_cr = !strip_cr;
                        use_mid  = 1'b1;
                    end
                end
                default: begin
                    // start of line, and the unused encodings
                    if (in_byte == CH_DOT) begin
                        step.ph_next = PH_DOT;
                    end else begin
                        use_mid = 1'b1;
                    end
                end
            endcase
        end

        if (use_mid) begin
            step.ph_next = m.ph;
        end

        // assemble up to two results in delivery order
        step.res[0] = m.res;
        step.res[1] = m.res;
        step.cnt    = 2'd0;
        if (eod) begin
            step.res[0].out_byte    = 8'h00;
            step.res[0].end_of_line = 1'b0;
            step.res[0].end_of_data = 1'b1;
            step.cnt                = 2'd1;
        end else if (extra_cr) begin
            step.res[0].out_byte    = CH_CR;
            step.res[0].end_of_line = 1'b0;
            step.res[0].end_of_data = 1'b0;
            step.cnt                = m.emit ? 2'd2 : 2'd1;
        end else if (use_mid && m.emit) begin
            step.cnt = 2'd1;
        end

        step.res[0].last = (step.cnt == 2'd1);
        step.res[1].last = (step.cnt == 2'd2);
    end

endmodule

>>> hdl/dup_fifo.sv
module dup_fifo
    import dup_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_cnt,
    input  res_t [1:0]       push_res,
    output logic [CNT_W-1:0] count,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    res_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    res_t             head;

    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = head.out_byte;
    assign m_tuser  = {head.end_of_data, head.end_of_line};
    assign m_tlast  = head.last;
    assign count    = cnt_reg;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_res[0];
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push_res[1];
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == CNT_W'(FIFO_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push_cnt == 2'd0) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("pop did not reduce count");

endmodule

>>> hdl/dot_unstuffing_parser.sv
// Channel   | Direction | tdata              | tuser                           | tlast
// ----------+-----------+--------------------+---------------------------------+---------------
// s_ (in)   | slave     | [7:0] in_byte      | [0] restart                     | -
// m_ (out)  | master    | [7:0] out_byte     | [0] end_of_line [1] end_of_data | last of byte
// cfg_      | write     | cfg_index 0 dot_mode, 1 strip_cr; cfg_wdata[0] value
//
// Throughput: one input byte per cycle while the result queue has room for two results;
//   a byte that yields two results (held CR plus the byte itself) fills two queue entries.
// Path: an accepted byte waits in the input register, dup_core decides it combinationally,
//   and its results are written into the result queue, whose head is presented on m_.
// Reset: aresetn synchronous, active low; dot_mode=0, strip_cr=1, start of line.
// Stalls: s_tready stays high while the input register is empty or moving on;
//   a byte moves on only while the 4-entry result queue has room for two
//   results, so with m_tready low s_tready drops once three or more wait.
module dot_unstuffing_parser
    import dup_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] restart
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] end_of_line, [1] end_of_data
    output logic       m_tlast,   // final result of this input byte
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_wdata
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;

    // configuration and line state
    logic       dot_mode_reg;
    logic       strip_cr_reg;
    phase_t     phase_reg, phase_next;

    logic             consume;
    logic             s_accept;
    logic [CNT_W-1:0] q_count;
    step_t            step;
    logic [1:0]       push_cnt;

    // A byte leaves the input register only when the queue has room for two results.
    assign consume  = in_valid_reg && (q_count <= CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || consume;
    assign s_accept = s_tvalid && s_tready;
    assign push_cnt = consume ? step.cnt : 2'd0;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
        phase_next = consume ? step.ph_next : phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_SOL;
            dot_mode_reg <= 1'b0;
            strip_cr_reg <= 1'b1;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_DOT_MODE: dot_mode_reg <= cfg_wdata;
                    CFG_STRIP_CR: strip_cr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
    end

    dup_core u_core (
        .in_byte  (in_byte_reg),
        .restart  (in_restart_reg),
        .phase    (phase_reg),
        .dot_mode (dot_mode_reg),
        .strip_cr (strip_cr_reg),
        .step     (step)
    );

    dup_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push_res (step.res),
        .count    (q_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_eod_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && phase_reg == PH_EOD && !in_restart_reg) |-> (step.cnt == 2'd0))
        else $error("result produced after end of data");

    a_eod_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && step.cnt != 2'd0 && step.res[0].end_of_data)
            |-> (step.cnt == 2'd1 && step.ph_next == PH_EOD))
        else $error("end of data result not alone");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && step.cnt == 2'd2) |-> (!step.res[0].last && step.res[1].last))
        else $error("last flag misplaced on result pair");

    a_held_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

endmodule
